FILE: hdl/ssfm_pkg.sv
// ssfm_pkg: shared types and constants of the substring first-match search block.
// Used by every module under hdl/; depends on nothing else.
`default_nettype none

package ssfm_pkg;

	// parameter defaults
	localparam int MAX_PATTERN_DEFAULT   = 16;
	localparam int POSITION_BITS_DEFAULT = 16;

	// pattern storage: two 64-bit registers, 16 bytes in all
	localparam int PAT_BYTES    = 16;
	localparam int PAT_IDX_BITS = 4;
	localparam int LEN_BITS     = 5;

	// configuration port
	localparam int DATA_BITS    = 64;
	localparam int ADDR_BITS    = 5;
	localparam int REG_IDX_BITS = 2;

	localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_LEN  = 2'd2;

	// front-to-back queue, power of two
	localparam int QUEUE_DEPTH = 4;

	// what the front found out about one item
	typedef struct packed {
		logic term;       // terminator item
		logic empty_pat;  // pattern length is zero
		logic hit;        // window plus this byte matches the pattern
	} ssfm_kind_t;

endpackage

`default_nettype wire

FILE: hdl/ssfm_front.sv
// ssfm_front: accepts text items, keeps the byte window and position count,
// and runs the parallel window compare. Depends on ssfm_pkg.
`default_nettype none

module ssfm_front #(
	parameter int MAX_PATTERN   = 16,
	parameter int POSITION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     text_valid,
	output logic                          text_stall,
	input  wire logic [7:0]               text_byte,
	input  wire logic                     end_of_text,
	input  wire logic [63:0]              pattern_bytes_low,
	input  wire logic [63:0]              pattern_bytes_high,
	input  wire logic [4:0]               pattern_length,
	input  wire logic                     queue_full,
	output logic                          push,
	output ssfm_pkg::ssfm_kind_t          kind,
	output logic [POSITION_BITS-1:0]      pos
);
	import ssfm_pkg::*;

	localparam int WIN = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [7:0]               window_q [WIN];
	logic [POSITION_BITS-1:0] count_q;
	logic [7:0]               pat [PAT_BYTES];
	logic [7:0]               seq [MAX_PATTERN];
	logic [LEN_BITS-1:0]      len;
	logic [LEN_BITS-1:0]      len_m1;
	logic [MAX_PATTERN-1:0]   eq;
	logic                     accept;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pat[i]     = pattern_bytes_low[8*i +: 8];
			pat[i + 8] = pattern_bytes_high[8*i +: 8];
		end
	end

	// seq[k] is the k-th newest byte, the incoming one first
	assign seq[0] = text_byte;
	for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_seq
		assign seq[k] = window_q[k-1];
	end

	assign len    = (32'(pattern_length) > MAX_PATTERN) ? LEN_BITS'(MAX_PATTERN)
	                                                     : pattern_length;
	assign len_m1 = len - 1'b1;

	// pattern byte len-1-k must equal the k-th newest byte
	always_comb begin
		logic [LEN_BITS-1:0] idx;
		logic [7:0]          pb;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			idx = len_m1 - LEN_BITS'(k);
			pb  = (32'(idx) < PAT_BYTES) ? pat[idx[PAT_IDX_BITS-1:0]] : 8'd0;
			if (k >= 32'(len)) begin
				eq[k] = 1'b1;
			end else begin
				eq[k] = (seq[k] == pb);
			end
		end
	end

	assign kind.term      = end_of_text;
	assign kind.empty_pat = (len == '0);
	assign kind.hit       = (len != '0) && (count_q >= POSITION_BITS'(len_m1)) && (&eq);
	assign pos            = (count_q == POS_MAX) ? POS_MAX
	                                             : count_q - POSITION_BITS'(len_m1);

	assign text_stall = queue_full;
	assign accept     = text_valid && !queue_full;
	assign push       = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				count_q <= '0;
			end else if (count_q != POS_MAX) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// the count gates every compare, so stale window bytes are never used
	always_ff @(posedge clk) begin
		if (accept && !end_of_text) begin
			window_q[0] <= text_byte;
			for (int i = 1; i < WIN; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ssfm_queue.sv
// ssfm_queue: short queue of classified items between front and back.
// Depends on ssfm_pkg.
`default_nettype none

module ssfm_queue #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire ssfm_pkg::ssfm_kind_t     kind_in,
	input  wire logic [POSITION_BITS-1:0] pos_in,
	input  wire logic                     pop,
	output logic                          full,
	output logic                          not_empty,
	output ssfm_pkg::ssfm_kind_t          kind_out,
	output logic [POSITION_BITS-1:0]      pos_out
);
	import ssfm_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	ssfm_kind_t               kind_mem_q [QUEUE_DEPTH];
	logic [POSITION_BITS-1:0] pos_mem_q  [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]      wr_ptr_q;
	logic [PTR_BITS-1:0]      rd_ptr_q;
	logic [CNT_BITS-1:0]      count_q;

	assign full      = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign kind_out  = kind_mem_q[rd_ptr_q];
	assign pos_out   = pos_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_mem_q[wr_ptr_q] <= kind_in;
			pos_mem_q[wr_ptr_q]  <= pos_in;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ssfm_back.sv
// ssfm_back: tracks whether the current text has been answered and drives the
// result register. Depends on ssfm_pkg.
`default_nettype none

module ssfm_back #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     head_valid,
	input  wire ssfm_pkg::ssfm_kind_t     kind,
	input  wire logic [POSITION_BITS-1:0] pos,
	output logic                          pop,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output logic                          found,
	output logic [POSITION_BITS-1:0]      match_position
);
	import ssfm_pkg::*;

	logic                     answered_q;
	logic                     result_valid_q;
	logic                     found_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     emit;
	logic                     emit_found;
	logic [POSITION_BITS-1:0] emit_pos;
	logic                     answered_d;

	always_comb begin
		emit       = 1'b0;
		emit_found = 1'b0;
		emit_pos   = '0;
		answered_d = answered_q;
		priority if (!answered_q && kind.empty_pat) begin
			// empty pattern matches at the first item, terminator included
			emit       = 1'b1;
			emit_found = 1'b1;
			answered_d = !kind.term;
		end else if (kind.term) begin
			emit       = !answered_q;
			answered_d = 1'b0;
		end else if (answered_q) begin
			answered_d = 1'b1;
		end else if (kind.hit) begin
			emit       = 1'b1;
			emit_found = 1'b1;
			emit_pos   = pos;
			answered_d = 1'b1;
		end else begin
			answered_d = 1'b0;
		end
	end

	assign pop            = head_valid && (!result_valid_q || !result_stall);
	assign result_valid   = result_valid_q;
	assign found          = found_q;
	assign match_position = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answered_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop && emit) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (pop) begin
				answered_q <= answered_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			found_q <= emit_found;
			pos_q   <= emit_pos;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/substring_first_match.sv
// Substring first-match search. Text bytes stream in one item per clock; the
// block reports the start position of the first occurrence of a pattern of up
// to MAX_PATTERN bytes (set over the register port), or not-found when the
// terminator item arrives. Sustained rate is one item per clock while the queue
// is not full, set by the combinational parallel window compare in the front
// stage; a result passes through the queue and the result register after its
// item is accepted. A four-entry queue between the compare stage and the result
// register absorbs result stalls, so text input keeps flowing until that queue
// fills. No start-up clearing pass. Positions saturate at 2**POSITION_BITS-1.
// Depends on ssfm_pkg, ssfm_front, ssfm_queue and ssfm_back.
`default_nettype none

module substring_first_match #(
	parameter int MAX_PATTERN   = ssfm_pkg::MAX_PATTERN_DEFAULT,
	parameter int POSITION_BITS = ssfm_pkg::POSITION_BITS_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [ssfm_pkg::ADDR_BITS-1:0]     paddr,
	input  wire logic [ssfm_pkg::DATA_BITS-1:0]     pwdata,
	output logic      [ssfm_pkg::DATA_BITS-1:0]     prdata,
	output logic                                    pready,
	// text in
	input  wire logic                               text_valid,
	output logic                                    text_stall,
	input  wire logic [7:0]                         text_byte,
	input  wire logic                               end_of_text,
	// result out
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic                                    found,
	output logic [POSITION_BITS-1:0]                match_position
);
	import ssfm_pkg::*;

	logic [63:0]              pattern_low_q;
	logic [63:0]              pattern_high_q;
	logic [LEN_BITS-1:0]      pattern_len_q;
	logic [REG_IDX_BITS-1:0]  reg_idx;
	logic                     cfg_write;

	ssfm_kind_t               front_kind;
	logic [POSITION_BITS-1:0] front_pos;
	logic                     push;
	logic                     queue_full;
	logic                     head_valid;
	ssfm_kind_t               head_kind;
	logic [POSITION_BITS-1:0] head_pos;
	logic                     pop;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_BITS-1 -: REG_IDX_BITS];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			pattern_len_q  <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_PATTERN_LOW:  pattern_low_q  <= pwdata[63:0];
				REG_PATTERN_HIGH: pattern_high_q <= pwdata[63:0];
				REG_PATTERN_LEN:  pattern_len_q  <= pwdata[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PATTERN_LOW:  prdata = pattern_low_q;
			REG_PATTERN_HIGH: prdata = pattern_high_q;
			REG_PATTERN_LEN:  prdata = DATA_BITS'(pattern_len_q);
			default:          prdata = '0;
		endcase
	end

	ssfm_front #(
		.MAX_PATTERN   (MAX_PATTERN),
		.POSITION_BITS (POSITION_BITS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.text_valid         (text_valid),
		.text_stall         (text_stall),
		.text_byte          (text_byte),
		.end_of_text        (end_of_text),
		.pattern_bytes_low  (pattern_low_q),
		.pattern_bytes_high (pattern_high_q),
		.pattern_length     (pattern_len_q),
		.queue_full         (queue_full),
		.push               (push),
		.kind               (front_kind),
		.pos                (front_pos)
	);

	ssfm_queue #(
		.POSITION_BITS (POSITION_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.kind_in   (front_kind),
		.pos_in    (front_pos),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (head_valid),
		.kind_out  (head_kind),
		.pos_out   (head_pos)
	);

	ssfm_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.kind           (head_kind),
		.pos            (head_pos),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.found          (found),
		.match_position (match_position)
	);

endmodule

`default_nettype wire
